FILE: src/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants of the fill-rectangle command generator.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 48;
	localparam int KIND_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int PANEL_W     = 9;
	localparam int COORD_W     = 16;
	localparam int COLOR_W     = 16;
	localparam int COUNT_W     = 17;

	localparam int QUEUE_DEPTH     = 2;
	localparam int RESULTS_PER_JOB = 12;

	localparam logic [7:0] CMD_COLUMN_SET   = 8'd42;
	localparam logic [7:0] CMD_ROW_SET      = 8'd43;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'd44;

	localparam logic [COUNT_W-1:0] PIXEL_COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BURST   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 2'd3;

	localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = 9'd128;
	localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = 9'd160;

	typedef struct packed {
		logic [PANEL_W-1:0] panel_width;
		logic [PANEL_W-1:0] panel_height;
		logic [7:0]         column_offset;
		logic [7:0]         row_offset;
	} cfg_t;

	// One accepted request, reduced to what the sequencer sends.
	typedef struct packed {
		logic [7:0]         col_start;
		logic [7:0]         col_end;
		logic [7:0]         row_start;
		logic [7:0]         row_end;
		logic [COLOR_W-1:0] color;
		logic [COUNT_W-1:0] count;
	} fill_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: src/lcd_fill_rect_command_gen_unit.sv
// ----------------------------------------------------------------------------
// lcd_fill_rect_command_gen_unit
// Turns fill-rectangle requests into address-window commands and a fill burst.
// ----------------------------------------------------------------------------
//  channel    dir  handshake                 contents
//  s_axis     in   s_axis_tvalid/tready      one fill request
//  m_axis     out  m_axis_tvalid/tready      command, data byte or fill burst
//  cfg        in   cfg_wr_en                 register write, no read-back
//
//  A drawn request yields twelve output transactions, one per cycle while the
//  output is not stalled, so the single output channel sets the rate; a rejected
//  request is accepted and yields nothing. Requests pass a clip
//  stage and a two-entry job queue, so new ones are taken while a job is sent.
//  Reset restores the register defaults; there is no clearing pass.
//  An output stall holds the sequencer; the input stalls once the queue fills.
// ----------------------------------------------------------------------------
module lcd_fill_rect_command_gen_unit import lfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// origin_x, origin_y, rect_width, rect_height, fill_color
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// byte_value, burst_color, pixel_count, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// kind
	output logic [KIND_W-1:0]      m_axis_tuser,
	output logic                   m_axis_tlast,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      push, pop;
	fill_job_t push_job, pop_job;
	q_status_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_width   <= PANEL_WIDTH_RST;
			cfg_q.panel_height  <= PANEL_HEIGHT_RST;
			cfg_q.column_offset <= 8'd0;
			cfg_q.row_offset    <= 8'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PANEL_WIDTH:   cfg_q.panel_width   <= cfg_data;
				REG_PANEL_HEIGHT:  cfg_q.panel_height  <= cfg_data;
				REG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data[7:0];
				REG_ROW_OFFSET:    cfg_q.row_offset    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	lfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_stat   (q_stat)
	);

	lfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.job      (pop_job),
		.pop      (pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast)
	);

endmodule

FILE: src/lfr_front.sv
// ----------------------------------------------------------------------------
// lfr_front
// Accepts fill requests, drops the ones that draw nothing, clips the rest and
// pushes a finished job into the queue.
// ----------------------------------------------------------------------------
module lfr_front import lfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  q_status_t             q_stat,
	output logic                  push,
	output fill_job_t             push_job
);

	logic [COORD_W-1:0] in_x, in_y, in_w, in_h;
	logic [COLOR_W-1:0] in_color;
	logic               in_ok;
	logic [COORD_W:0]   end_x, end_y;
	logic [PANEL_W-1:0] clip_w, clip_h;
	logic               advance;

	logic               valid_s1;
	logic [7:0]         x_s1, y_s1;
	logic [PANEL_W-1:0] w_s1, h_s1;
	logic [COLOR_W-1:0] color_s1;

	logic [2*PANEL_W-1:0] product;

	assign in_x     = s_tdata[15:0];
	assign in_y     = s_tdata[31:16];
	assign in_w     = s_tdata[47:32];
	assign in_h     = s_tdata[63:48];
	assign in_color = s_tdata[79:64];

	assign in_ok = (in_x < {{(COORD_W-PANEL_W){1'b0}}, cfg.panel_width})
		&& (in_y < {{(COORD_W-PANEL_W){1'b0}}, cfg.panel_height})
		&& (in_w != '0) && (in_h != '0);

	assign end_x = {1'b0, in_x} + {1'b0, in_w} - 17'd1;
	assign end_y = {1'b0, in_y} + {1'b0, in_h} - 17'd1;

	// With the origin inside the panel, an unclipped size already fits in nine bits.
	always_comb begin
		if (end_x >= {{(COORD_W+1-PANEL_W){1'b0}}, cfg.panel_width}) begin
			clip_w = cfg.panel_width - in_x[PANEL_W-1:0];
		end else begin
			clip_w = in_w[PANEL_W-1:0];
		end
		if (end_y >= {{(COORD_W+1-PANEL_W){1'b0}}, cfg.panel_height}) begin
			clip_h = cfg.panel_height - in_y[PANEL_W-1:0];
		end else begin
			clip_h = in_h[PANEL_W-1:0];
		end
	end

	assign advance  = !valid_s1 || !q_stat.full;
	assign s_tready = advance;
	assign push     = valid_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid && in_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s1     <= in_x[7:0];
			y_s1     <= in_y[7:0];
			w_s1     <= clip_w;
			h_s1     <= clip_h;
			color_s1 <= in_color;
		end
	end

	assign product = w_s1 * h_s1;

	always_comb begin
		push_job.col_start = x_s1 + cfg.column_offset;
		push_job.col_end   = x_s1 + w_s1[7:0] - 8'd1 + cfg.column_offset;
		push_job.row_start = y_s1 + cfg.row_offset;
		push_job.row_end   = y_s1 + h_s1[7:0] - 8'd1 + cfg.row_offset;
		push_job.color     = color_s1;
		if (product[2*PANEL_W-1:COUNT_W] != '0) begin
			push_job.count = PIXEL_COUNT_MAX;
		end else begin
			push_job.count = product[COUNT_W-1:0];
		end
	end

endmodule

FILE: src/lfr_queue.sv
// ----------------------------------------------------------------------------
// lfr_queue
// Short job queue between the request front end and the command sequencer.
// ----------------------------------------------------------------------------
module lfr_queue import lfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  fill_job_t push_job,
	input  logic      pop,
	output fill_job_t pop_job,
	output q_status_t q_stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	fill_job_t        slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == CNT_FULL);
	assign q_stat.empty = (count_q == '0);
	assign pop_job      = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

FILE: src/lfr_back.sv
// ----------------------------------------------------------------------------
// lfr_back
// Command sequencer: turns one queued job into twelve controller transactions.
// ----------------------------------------------------------------------------
module lfr_back import lfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_status_t              q_stat,
	input  fill_job_t              job,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [KIND_W-1:0]      m_tuser,
	output logic                   m_tlast
);

	localparam int STEP_W = $clog2(RESULTS_PER_JOB);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RESULTS_PER_JOB - 1);

	fill_job_t          cur_q;
	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic               m_valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [7:0]         byte_q;
	logic [COLOR_W-1:0] color_q;
	logic [COUNT_W-1:0] count_q;
	logic               last_q;

	logic               out_free, emit, finish;
	logic [KIND_W-1:0]  r_kind;
	logic [7:0]         r_byte;
	logic [COLOR_W-1:0] r_color;
	logic [COUNT_W-1:0] r_count;
	logic               r_last;

	assign out_free = !m_valid_q || m_tready;
	assign emit     = busy_q && out_free;
	assign finish   = emit && (step_q == LAST_STEP);
	// The next job is loaded while idle, or in the same cycle as the burst of the current one is registered.
	assign pop      = !q_stat.empty && (!busy_q || finish);

	always_comb begin
		r_kind  = KIND_DATA;
		r_byte  = 8'd0;
		r_color = '0;
		r_count = '0;
		r_last  = 1'b0;
		case (step_q)
			4'd0: begin
				r_kind = KIND_COMMAND;
				r_byte = CMD_COLUMN_SET;
			end
			4'd2: r_byte = cur_q.col_start;
			4'd4: r_byte = cur_q.col_end;
			4'd5: begin
				r_kind = KIND_COMMAND;
				r_byte = CMD_ROW_SET;
			end
			4'd7: r_byte = cur_q.row_start;
			4'd9: r_byte = cur_q.row_end;
			4'd10: begin
				r_kind = KIND_COMMAND;
				r_byte = CMD_MEMORY_WRITE;
			end
			4'd11: begin
				r_kind  = KIND_BURST;
				r_color = cur_q.color;
				r_count = cur_q.count;
				r_last  = 1'b1;
			end
			default: r_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (out_free) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= job;
		end
		if (emit) begin
			kind_q  <= r_kind;
			byte_q  <= r_byte;
			color_q <= r_color;
			count_q <= r_count;
			last_q  <= r_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_TDATA_W-COUNT_W-COLOR_W-8){1'b0}}, count_q, color_q, byte_q};

`ifndef SYNTHESIS
	a_last_is_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && last_q |-> kind_q == KIND_BURST)
		else $error("last transaction is not a fill burst");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= LAST_STEP)
		else $error("sequencer step out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("job taken from an empty queue");

	a_idle_after_job: assert property (@(posedge clk) disable iff (!arst_n)
		finish && q_stat.empty |=> !busy_q && m_valid_q && last_q)
		else $error("sequencer did not end the job with its burst");
`endif

endmodule

FILE: dv/lcd_fill_rect_command_gen_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_fill_rect_command_gen_unit_tb
// Self-checking bench for the fill-rectangle command generator. A queue-fed
// driver sends fill requests with random gaps and a clocked monitor checks
// every output transaction against a predictor of the window and burst
// traffic. Panel sizes and offsets are reprogrammed between phases while the
// block is idle, reaching rejection, clipping, truncation and saturation.
// ----------------------------------------------------------------------------
module lcd_fill_rect_command_gen_unit_tb;
	import lfr_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int SETTLE_TICKS = 32;
	localparam int DRAIN_EVERY  = 97;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [7:0]         byte_value;
		logic [COLOR_W-1:0] burst_color;
		logic [COUNT_W-1:0] pixel_count;
		logic               last;
	} beat_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0]      m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	// Shadow copy of the panel registers, as the block holds them.
	int unsigned mdl_panel_w = PANEL_WIDTH_RST;
	int unsigned mdl_panel_h = PANEL_HEIGHT_RST;
	int unsigned mdl_col_off = 0;
	int unsigned mdl_row_off = 0;

	logic [IN_TDATA_W-1:0] fill_req_q[$];
	beat_t                 traffic_exp_q[$];

	int unsigned src_idle_pct  = 20;
	int unsigned sink_idle_pct = 20;
	int unsigned accepted_cnt  = 0;
	int unsigned fail_cnt      = 0;
	bit          drain_hold    = 1'b0;

	lcd_fill_rect_command_gen_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic void push_beat(input logic [KIND_W-1:0] kind, input int unsigned value,
			input int unsigned color, input int unsigned count, input logic last);
		beat_t b;
		b.kind        = kind;
		b.byte_value  = value[7:0];
		b.burst_color = color[COLOR_W-1:0];
		b.pixel_count = count[COUNT_W-1:0];
		b.last        = last;
		traffic_exp_q.push_back(b);
	endfunction

	// Works out the twelve transactions of one drawn request, or none if rejected.
	function automatic void predict_fill(input logic [IN_TDATA_W-1:0] req);
		int unsigned x, y, w, h, color, count, x_end, y_end;
		x     = req[15:0];
		y     = req[31:16];
		w     = req[47:32];
		h     = req[63:48];
		color = req[79:64];
		if (x >= mdl_panel_w || y >= mdl_panel_h || w == 0 || h == 0)
			return;
		if (x + w - 1 >= mdl_panel_w)
			w = mdl_panel_w - x;
		if (y + h - 1 >= mdl_panel_h)
			h = mdl_panel_h - y;
		count = w * h;
		if (count > PIXEL_COUNT_MAX)
			count = PIXEL_COUNT_MAX;
		x_end = x + w - 1;
		y_end = y + h - 1;
		push_beat(KIND_COMMAND, CMD_COLUMN_SET, 0, 0, 1'b0);
		push_beat(KIND_DATA, 0, 0, 0, 1'b0);
		push_beat(KIND_DATA, x + mdl_col_off, 0, 0, 1'b0);
		push_beat(KIND_DATA, 0, 0, 0, 1'b0);
		push_beat(KIND_DATA, x_end + mdl_col_off, 0, 0, 1'b0);
		push_beat(KIND_COMMAND, CMD_ROW_SET, 0, 0, 1'b0);
		push_beat(KIND_DATA, 0, 0, 0, 1'b0);
		push_beat(KIND_DATA, y + mdl_row_off, 0, 0, 1'b0);
		push_beat(KIND_DATA, 0, 0, 0, 1'b0);
		push_beat(KIND_DATA, y_end + mdl_row_off, 0, 0, 1'b0);
		push_beat(KIND_COMMAND, CMD_MEMORY_WRITE, 0, 0, 1'b0);
		push_beat(KIND_BURST, 0, color, count, 1'b1);
	endfunction

	// Request driver: holds a transaction until accepted, then picks the next.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (s_axis_tvalid) begin
				predict_fill(s_axis_tdata);
				accepted_cnt++;
				if (accepted_cnt % DRAIN_EVERY == 0)
					drain_hold = 1'b1;
			end
			if (drain_hold && traffic_exp_q.size() == 0)
				drain_hold = 1'b0;
			if (fill_req_q.size() != 0 && !drain_hold &&
					$urandom_range(99, 0) >= src_idle_pct) begin
				s_axis_tdata  <= fill_req_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output monitor with random backpressure.
	always @(posedge clk) begin
		beat_t exp_b;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (traffic_exp_q.size() == 0) begin
				$error("unexpected output transaction: kind %0d data 0x%h",
					m_axis_tuser, m_axis_tdata);
				fail_cnt++;
			end else begin
				exp_b = traffic_exp_q.pop_front();
				if (m_axis_tuser !== exp_b.kind) begin
					$error("kind: expected %0d, actual %0d", exp_b.kind, m_axis_tuser);
					fail_cnt++;
				end
				if (m_axis_tdata[7:0] !== exp_b.byte_value) begin
					$error("byte_value: expected 0x%h, actual 0x%h",
						exp_b.byte_value, m_axis_tdata[7:0]);
					fail_cnt++;
				end
				if (m_axis_tdata[23:8] !== exp_b.burst_color) begin
					$error("burst_color: expected 0x%h, actual 0x%h",
						exp_b.burst_color, m_axis_tdata[23:8]);
					fail_cnt++;
				end
				if (m_axis_tdata[40:24] !== exp_b.pixel_count) begin
					$error("pixel_count: expected %0d, actual %0d",
						exp_b.pixel_count, m_axis_tdata[40:24]);
					fail_cnt++;
				end
				if (m_axis_tlast !== exp_b.last) begin
					$error("last: expected %0d, actual %0d", exp_b.last, m_axis_tlast);
					fail_cnt++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
	end

	function automatic void push_req(input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h, input int unsigned color);
		fill_req_q.push_back({color[15:0], h[15:0], w[15:0], y[15:0], x[15:0]});
	endfunction

	task automatic program_panel(input int unsigned pw, input int unsigned ph,
			input int unsigned co, input int unsigned ro);
		logic [CFG_IDX_W-1:0]  idx[4];
		logic [CFG_DATA_W-1:0] val[4];
		idx[0] = REG_PANEL_WIDTH;
		idx[1] = REG_PANEL_HEIGHT;
		idx[2] = REG_COLUMN_OFFSET;
		idx[3] = REG_ROW_OFFSET;
		val[0] = pw[CFG_DATA_W-1:0];
		val[1] = ph[CFG_DATA_W-1:0];
		val[2] = co[CFG_DATA_W-1:0];
		val[3] = ro[CFG_DATA_W-1:0];
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
		end
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		mdl_panel_w = pw & 32'h1FF;
		mdl_panel_h = ph & 32'h1FF;
		mdl_col_off = co & 32'hFF;
		mdl_row_off = ro & 32'hFF;
	endtask

	// Waits until every request is taken and answered, then lets the pipe settle.
	task automatic drain_all;
		do
			@(posedge clk);
		while (fill_req_q.size() != 0 || s_axis_tvalid || traffic_exp_q.size() != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// Mostly well-formed rectangles on the current panel, the rest noise.
	task automatic push_random_phase(input int unsigned draws);
		int unsigned x, y, w, h, drawn, tries;
		drawn = 0;
		tries = 0;
		while (drawn < draws && tries < draws * 4) begin
			tries++;
			if ($urandom_range(99, 0) < 80) begin
				x = $urandom_range(mdl_panel_w - 1, 0);
				y = $urandom_range(mdl_panel_h - 1, 0);
				case ($urandom_range(3, 0))
					0: w = $urandom_range(mdl_panel_w - x, 1);
					1: w = $urandom_range(8, 1);
					2: w = $urandom_range(mdl_panel_w - x + 40, mdl_panel_w - x);
					default: w = $urandom() & 32'hFFFF;
				endcase
				case ($urandom_range(3, 0))
					0: h = $urandom_range(mdl_panel_h - y, 1);
					1: h = $urandom_range(8, 1);
					2: h = $urandom_range(mdl_panel_h - y + 40, mdl_panel_h - y);
					default: h = $urandom() & 32'hFFFF;
				endcase
			end else begin
				x = $urandom() & 32'hFFFF;
				y = $urandom() & 32'hFFFF;
				w = $urandom() & 32'hFFFF;
				h = $urandom() & 32'hFFFF;
				case ($urandom_range(2, 0))
					0: x = mdl_panel_w + $urandom_range(300, 0);
					1: begin
						x = $urandom_range(mdl_panel_w - 1, 0);
						y = $urandom_range(mdl_panel_h - 1, 0);
						if ($urandom_range(1, 0))
							w = 0;
						else
							h = 0;
					end
					default: ;
				endcase
			end
			if (x < mdl_panel_w && y < mdl_panel_h && w != 0 && h != 0)
				drawn++;
			push_req(x, y, w, h, $urandom() & 32'hFFFF);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset panel: full screen, corners, rejections and clipping.
		push_req(0, 0, 128, 160, 16'hFFFF);
		push_req(0, 0, 1, 1, 16'h0000);
		push_req(127, 159, 1, 1, 16'hA5A5);
		push_req(128, 0, 5, 5, 16'h1111);
		push_req(0, 160, 5, 5, 16'h2222);
		push_req(10, 10, 0, 5, 16'h3333);
		push_req(10, 10, 5, 0, 16'h4444);
		push_req(100, 150, 16'hFFFF, 16'hFFFF, 16'h5A5A);
		push_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_req(5, 7, 20, 30, 16'h1234);
		drain_all();

		// Largest nominal panel with maximum offsets: coordinate bytes wrap.
		program_panel(256, 256, 255, 255);
		push_req(0, 0, 256, 256, 16'hFFFF);
		push_req(255, 255, 1, 1, 16'h0001);
		push_req(200, 10, 16'hFFFF, 3, 16'h8000);
		drain_all();

		// Oversized registers: the pixel count saturates.
		program_panel(511, 511, 1, 2);
		push_req(0, 0, 511, 511, 16'h07E0);
		push_req(0, 0, 16'hFFFF, 16'hFFFF, 16'h001F);
		push_req(510, 510, 1, 1, 16'hF800);
		drain_all();

		// A zero panel dimension rejects everything.
		program_panel(0, 160, 0, 0);
		push_req(0, 0, 1, 1, 16'hC3C3);
		drain_all();
		program_panel(128, 0, 0, 0);
		push_req(0, 0, 1, 1, 16'h3C3C);
		drain_all();

		program_panel(1, 1, 17, 34);
		push_req(0, 0, 1, 1, 16'hBEEF);
		push_req(0, 0, 5, 5, 16'hDEAD);
		push_req(1, 0, 1, 1, 16'hCAFE);
		drain_all();

		// Back-to-back stretch with neither side idling.
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		program_panel(128, 160, 0, 0);
		push_random_phase(48);
		drain_all();
		src_idle_pct  = 20;
		sink_idle_pct = 20;

		for (int p = 0; p < 5; p++) begin
			program_panel($urandom_range(256, 1), $urandom_range(256, 1),
				$urandom_range(255, 0), $urandom_range(255, 0));
			push_random_phase(48);
			drain_all();
		end

		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
